FILE: rtl/core/jet_pkg.sv
// Shared types, constants and helpers of the Julia set escape-time unit.
// No dependencies; every other file of the unit imports this package.
package jet_pkg;

  localparam int COORD_W    = 32;
  localparam int STEP_W     = 31;
  localparam int ITER_W     = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int MIN_ITER   = 10;

  localparam logic [CFG_IDX_W-1:0] REG_C_REAL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_C_IMAG   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_MIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_MAX    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_X   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_Y   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 3'd6;

  localparam logic signed [COORD_W-1:0] RST_C_REAL   = -32'sd201863463;
  localparam logic signed [COORD_W-1:0] RST_C_IMAG   = 32'sd31406948;
  localparam logic signed [COORD_W-1:0] RST_X_MIN    = -32'sd536870912;
  localparam logic signed [COORD_W-1:0] RST_Y_MAX    = 32'sd536870912;
  localparam logic [STEP_W-1:0]         RST_STEP_X   = 31'd3579139;
  localparam logic [STEP_W-1:0]         RST_STEP_Y   = 31'd3579139;
  localparam logic [ITER_W-1:0]         RST_MAX_ITER = 10'd1000;

  typedef struct packed {
    logic signed [COORD_W-1:0] c_real;
    logic signed [COORD_W-1:0] c_imag;
    logic signed [COORD_W-1:0] x_min;
    logic signed [COORD_W-1:0] y_max;
    logic [STEP_W-1:0]         step_x;
    logic [STEP_W-1:0]         step_y;
    logic [ITER_W-1:0]         max_iter;
  } jet_cfg_t;

  typedef struct packed {
    logic load;
    logic init;
    logic square;
    logic update;
    logic fin_esc;
    logic fin_lim;
  } jet_cmd_t;

  typedef struct packed {
    logic escape;
    logic at_limit;
  } jet_sts_t;

  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sh0000_0000_7FFF_FFFF;
    lo = -64'sh0000_0000_8000_0000;
    if (v > hi) begin
      sat32 = hi[COORD_W-1:0];
    end else if (v < lo) begin
      sat32 = lo[COORD_W-1:0];
    end else begin
      sat32 = v[COORD_W-1:0];
    end
  endfunction

endpackage

FILE: rtl/core/julia_escape_time_unit.sv
// Julia set escape-time unit, top level: config registers, sequencer, datapath.
// Depends on jet_pkg, jet_cfg, jet_ctrl and jet_dp.
// One pixel at a time. A pixel ends with its result beat either when it escapes
// or, if it stays bounded, when its iteration count reaches the limit.
// Each iteration runs the squaring multipliers, then the update.
// Synchronous reset returns the config registers to their defaults and idles.
module julia_escape_time_unit import jet_pkg::*; #(
  parameter int FRAC_BITS  = 28,
  parameter int PIXEL_BITS = 12,
  parameter int ITER_LIMIT = 1000
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [PIXEL_BITS-1:0] in_pixel_col,
  input  logic [PIXEL_BITS-1:0] in_pixel_row,
  output logic                  out_valid,
  output logic [ITER_W-1:0]     out_iter_count,
  output logic                  out_escaped,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  jet_cfg_t cfg;
  jet_cmd_t cmd;
  jet_sts_t sts;

  jet_cfg u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (cfg_we),
    .idx   (cfg_index),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  jet_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  jet_dp #(
    .FRAC_BITS  (FRAC_BITS),
    .PIXEL_BITS (PIXEL_BITS),
    .ITER_LIMIT (ITER_LIMIT)
  ) u_dp (
    .clk        (clk),
    .cmd        (cmd),
    .cfg        (cfg),
    .pixel_col  (in_pixel_col),
    .pixel_row  (in_pixel_row),
    .sts        (sts),
    .iter_count (out_iter_count),
    .escaped    (out_escaped)
  );

endmodule

FILE: rtl/core/jet_cfg.sv
// Configuration register file of the Julia set escape-time unit.
// Depends on jet_pkg for the register indexes, reset values and jet_cfg_t.
module jet_cfg import jet_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  we,
  input  logic [CFG_IDX_W-1:0]  idx,
  input  logic [CFG_DATA_W-1:0] wdata,
  output jet_cfg_t              cfg
);

  jet_cfg_t cfg_r;
  jet_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (we) begin
      unique case (idx)
        REG_C_REAL:   cfg_nxt.c_real   = wdata;
        REG_C_IMAG:   cfg_nxt.c_imag   = wdata;
        REG_X_MIN:    cfg_nxt.x_min    = wdata;
        REG_Y_MAX:    cfg_nxt.y_max    = wdata;
        REG_STEP_X:   cfg_nxt.step_x   = wdata[STEP_W-1:0];
        REG_STEP_Y:   cfg_nxt.step_y   = wdata[STEP_W-1:0];
        REG_MAX_ITER: cfg_nxt.max_iter = wdata[ITER_W-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.c_real   <= RST_C_REAL;
      cfg_r.c_imag   <= RST_C_IMAG;
      cfg_r.x_min    <= RST_X_MIN;
      cfg_r.y_max    <= RST_Y_MAX;
      cfg_r.step_x   <= RST_STEP_X;
      cfg_r.step_y   <= RST_STEP_Y;
      cfg_r.max_iter <= RST_MAX_ITER;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/core/jet_dp.sv
// Datapath of the Julia set escape-time unit: start point, squarer and update.
// Depends on jet_pkg for jet_cfg_t, jet_cmd_t, jet_sts_t and sat32.
module jet_dp import jet_pkg::*; #(
  parameter int FRAC_BITS  = 28,
  parameter int PIXEL_BITS = 12,
  parameter int ITER_LIMIT = 1000
) (
  input  logic                  clk,
  input  jet_cmd_t              cmd,
  input  jet_cfg_t              cfg,
  input  logic [PIXEL_BITS-1:0] pixel_col,
  input  logic [PIXEL_BITS-1:0] pixel_row,
  output jet_sts_t              sts,
  output logic [ITER_W-1:0]     iter_count,
  output logic                  escaped
);

  localparam int KW = $clog2(ITER_LIMIT + 1);
  localparam int PW = PIXEL_BITS + STEP_W;
  localparam bit CAN_ESC = (2 * FRAC_BITS + 2) < 64;
  localparam logic [64:0] THRESH = CAN_ESC ? (65'd1 << (2 * FRAC_BITS + 2)) : '0;

  logic [PW-1:0]              prod_x_r, prod_y_r;
  logic signed [COORD_W-1:0]  x_r, y_r;
  logic signed [63:0]         xx_r, yy_r, xy_r;
  logic [KW-1:0]              k_r, limit_r;
  logic [ITER_W-1:0]          iter_count_r;
  logic                       escaped_r;

  logic [PW-1:0]              prod_x_nxt, prod_y_nxt;
  logic signed [63:0]         start_x, start_y;
  logic signed [63:0]         xx_nxt, yy_nxt, xy_nxt;
  logic signed [63:0]         diff, diff_sh, xy_sh, nx_sum, ny_sum;
  logic [64:0]                mag;
  logic [31:0]                mi32, lim32;
  logic [31:0]                cnt32;

  assign prod_x_nxt = PW'(pixel_col) * PW'(cfg.step_x);
  assign prod_y_nxt = PW'(pixel_row) * PW'(cfg.step_y);

  assign start_x = $signed({{32{cfg.x_min[COORD_W-1]}}, cfg.x_min}) +
                   $signed(64'(prod_x_r));
  assign start_y = $signed({{32{cfg.y_max[COORD_W-1]}}, cfg.y_max}) -
                   $signed(64'(prod_y_r));

  assign xx_nxt = 64'(x_r) * 64'(x_r);
  assign yy_nxt = 64'(y_r) * 64'(y_r);
  assign xy_nxt = 64'(x_r) * 64'(y_r);

  assign diff    = xx_r - yy_r;
  assign diff_sh = diff >>> FRAC_BITS;
  assign xy_sh   = xy_r >>> (FRAC_BITS - 1);
  assign nx_sum  = diff_sh + $signed({{32{cfg.c_real[COORD_W-1]}}, cfg.c_real});
  assign ny_sum  = xy_sh + $signed({{32{cfg.c_imag[COORD_W-1]}}, cfg.c_imag});

  assign mag = {1'b0, xx_r} + {1'b0, yy_r};

  always_comb begin
    mi32 = 32'(cfg.max_iter);
    if (mi32 < 32'(MIN_ITER)) begin
      lim32 = 32'(MIN_ITER);
    end else if (mi32 > 32'(ITER_LIMIT)) begin
      lim32 = 32'(ITER_LIMIT);
    end else begin
      lim32 = mi32;
    end
  end

  always_comb begin
    if (cmd.fin_esc) begin
      cnt32 = 32'(k_r) - 32'd1;
    end else begin
      cnt32 = 32'(k_r);
    end
  end

  assign sts.escape   = CAN_ESC && (k_r != '0) && (mag > THRESH);
  assign sts.at_limit = (k_r == limit_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      prod_x_r <= prod_x_nxt;
      prod_y_r <= prod_y_nxt;
      limit_r  <= lim32[KW-1:0];
    end
    if (cmd.init) begin
      x_r <= sat32(start_x);
      y_r <= sat32(start_y);
      k_r <= '0;
    end
    if (cmd.square) begin
      xx_r <= xx_nxt;
      yy_r <= yy_nxt;
      xy_r <= xy_nxt;
    end
    if (cmd.update) begin
      x_r <= sat32(nx_sum);
      y_r <= sat32(ny_sum);
      k_r <= k_r + 1'b1;
    end
    if (cmd.fin_esc || cmd.fin_lim) begin
      iter_count_r <= cnt32[ITER_W-1:0];
      escaped_r    <= cmd.fin_esc;
    end
  end

  assign iter_count = iter_count_r;
  assign escaped    = escaped_r;

endmodule

FILE: rtl/core/jet_ctrl.sv
// Sequencer of the Julia set escape-time unit: steps the datapath per pixel.
// Depends on jet_pkg for jet_cmd_t and jet_sts_t.
module jet_ctrl import jet_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  jet_sts_t sts,
  output jet_cmd_t cmd,
  output logic     busy,
  output logic     out_valid
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_INIT = 2'd1;
  localparam logic [1:0] ST_SQ   = 2'd2;
  localparam logic [1:0] ST_UPD  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = ST_SQ;
      end
      ST_SQ: begin
        cmd.square = 1'b1;
        state_nxt  = ST_UPD;
      end
      ST_UPD: begin
        if (sts.escape) begin
          cmd.fin_esc   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else if (sts.at_limit) begin
          cmd.fin_lim   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          cmd.update = 1'b1;
          state_nxt  = ST_SQ;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule
